[sv/sldf_pkg.sv]
package sldf_pkg;

    localparam logic [7:0] SYNC_BYTE  = 8'hFF;
    localparam int         BYTE_W     = 8;
    localparam int         WORD_W     = 16;
    localparam int         M_TDATA_W  = 64;

    typedef struct packed {
        logic              is_frame_end;
        logic              checksum_good;
        logic [WORD_W-1:0] frame_length;
        logic [WORD_W-1:0] command_word;
        logic [WORD_W-1:0] payload_index;
        logic [BYTE_W-1:0] payload_byte;
    } result_t;

    localparam int RES_DATA_W = $bits(result_t) - 1;

endpackage

[sv/sync_length_checksum_deframer.sv]
// Frame parser for a byte stream: FF FF cmd_lo cmd_hi len_lo len_hi payload checksum.
// Input channel s_*: one received byte per request in s_tdata.
// Result channel m_*: one request per payload byte (m_tuser = 0) carrying the byte,
// its index, the command and the length; one request per frame end (m_tuser = 1)
// carrying the command, the length and the checksum match flag. Sync, header
// and dropped bytes produce no result.
// Each result is registered, in the skid register if the result register is held.
// Throughput: one byte per cycle while s_tready is high; the parser state update
// (phase, counter and 8-bit sum) is combinational logic before the result register.
// A two-entry output stage (result register plus skid register) lets a byte be
// accepted while a result waits; s_tready falls only when both entries are full,
// so a stalled receiver backs up the sender one result-producing byte later.
// Reset (aresetn low, synchronous): parser returns to hunting for the first
// sync byte and both output entries are emptied.
module sync_length_checksum_deframer
    import sldf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] payload_byte, [23:8] payload_index,
                                            // [39:24] command_word, [55:40] frame_length,
                                            // [56] checksum_good, zero above
    output logic                 m_tuser    // [0] is_frame_end
);

    typedef enum logic [2:0] {
        PH_HUNT1, PH_HUNT2, PH_CMD_LO, PH_CMD_HI,
        PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD, PH_CHECK
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [WORD_W-1:0]  command_reg, command_next;
    logic [WORD_W-1:0]  length_reg, length_next;
    logic [WORD_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0]  sum_reg, sum_next;
    result_t            out_reg, skid_reg, res;
    logic               out_valid_reg, skid_valid_reg;
    logic               res_valid;
    logic               s_accept, m_take;

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_take   = out_valid_reg && m_tready;
    assign m_tuser  = out_reg.is_frame_end;
    assign m_tdata  = {{(M_TDATA_W - RES_DATA_W){1'b0}}, out_reg[RES_DATA_W-1:0]};

    always_comb begin
        phase_next        = phase_reg;
        command_next      = command_reg;
        length_next       = length_reg;
        count_next        = count_reg;
        sum_next          = sum_reg;
        res_valid         = 1'b0;
        res.is_frame_end  = 1'b0;
        res.checksum_good = 1'b0;
        res.frame_length  = length_reg;
        res.command_word  = command_reg;
        res.payload_index = count_reg;
        res.payload_byte  = s_tdata;
        unique case (phase_reg)
            PH_HUNT1: begin
                count_next = '0;
                sum_next   = '0;
                phase_next = (s_tdata == SYNC_BYTE) ? PH_HUNT2 : PH_HUNT1;
            end
            PH_HUNT2: begin
                phase_next = (s_tdata == SYNC_BYTE) ? PH_CMD_LO : PH_HUNT1;
            end
            PH_CMD_LO: begin
                command_next = {{(WORD_W - BYTE_W){1'b0}}, s_tdata};
                phase_next   = PH_CMD_HI;
            end
            PH_CMD_HI: begin
                command_next = {s_tdata, command_reg[BYTE_W-1:0]};
                phase_next   = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                length_next = {{(WORD_W - BYTE_W){1'b0}}, s_tdata};
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                length_next = {s_tdata, length_reg[BYTE_W-1:0]};
                count_next  = '0;
                sum_next    = '0;
                phase_next  = (length_next == '0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                res_valid  = 1'b1;
                sum_next   = sum_reg + s_tdata;
                count_next = count_reg + 1'b1;
                if (count_next == length_reg) begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK: begin
                res_valid         = 1'b1;
                res.is_frame_end  = 1'b1;
                res.checksum_good = (sum_reg == s_tdata);
                res.payload_index = '0;
                res.payload_byte  = '0;
                count_next        = '0;
                sum_next          = '0;
                phase_next        = PH_HUNT1;
            end
            default: begin
                phase_next = PH_HUNT1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT1;
            command_reg    <= '0;
            length_reg     <= '0;
            count_reg      <= '0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                phase_reg   <= phase_next;
                command_reg <= command_next;
                length_reg  <= length_next;
                count_reg   <= count_next;
                sum_reg     <= sum_next;
            end
            if (m_take && skid_valid_reg) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else if (s_accept && res_valid) begin
                if (!out_valid_reg || m_take) begin
                    out_reg       <= res;
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_reg       <= res;
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_take) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while result register empty");

    a_end_clears_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.is_frame_end) |->
        (out_reg.payload_byte == '0 && out_reg.payload_index == '0))
        else $error("frame end carries payload fields");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !out_reg.is_frame_end) |->
        (out_reg.payload_index < out_reg.frame_length))
        else $error("payload index beyond frame length");

    a_check_follows_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && phase_reg == PH_CHECK) |=> (phase_reg == PH_HUNT1))
        else $error("parser did not return to hunting after checksum");

    a_stall_holds_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

[dv/sldf_checker.sv]
module sldf_checker
    import sldf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // [7:0] payload_byte, [23:8] payload_index,
                                            // [39:24] command_word, [55:40] frame_length,
                                            // [56] checksum_good, zero above
    input  logic                 m_tuser,   // [0] is_frame_end
    output int                   mismatches,
    output int                   results_due,
    output int                   payload_count,
    output int                   frame_count,
    output int                   bad_sum_count
);

    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        CMD_LO,
        CMD_HI,
        LEN_LO,
        LEN_HI,
        PAYLOAD,
        CHECKSUM
    } parse_phase_t;

    parse_phase_t      phase = HUNT_FIRST;
    logic [WORD_W-1:0] command_q = '0;
    logic [WORD_W-1:0] length_q = '0;
    logic [WORD_W-1:0] index_q = '0;
    logic [BYTE_W-1:0] sum_q = '0;
    result_t           awaited_results[$];

    task automatic parse_byte(input logic [BYTE_W-1:0] rx);
        result_t r;
        r = '0;
        case (phase)
            HUNT_FIRST: begin
                index_q = '0;
                sum_q   = '0;
                phase   = (rx == SYNC_BYTE) ? HUNT_SECOND : HUNT_FIRST;
            end
            HUNT_SECOND: begin
                phase = (rx == SYNC_BYTE) ? CMD_LO : HUNT_FIRST;
            end
            CMD_LO: begin
                command_q = {8'h00, rx};
                phase     = CMD_HI;
            end
            CMD_HI: begin
                command_q = command_q | {rx, 8'h00};
                phase     = LEN_LO;
            end
            LEN_LO: begin
                length_q = {8'h00, rx};
                phase    = LEN_HI;
            end
            LEN_HI: begin
                length_q = length_q | {rx, 8'h00};
                index_q  = '0;
                sum_q    = '0;
                phase    = (length_q == '0) ? CHECKSUM : PAYLOAD;
            end
            PAYLOAD: begin
                r.payload_byte  = rx;
                r.payload_index = index_q;
                r.command_word  = command_q;
                r.frame_length  = length_q;
                awaited_results.push_back(r);
                sum_q   = sum_q + rx;
                index_q = index_q + 1'b1;
                if (index_q == length_q) begin
                    phase = CHECKSUM;
                end
            end
            default: begin
                r.is_frame_end  = 1'b1;
                r.command_word  = command_q;
                r.frame_length  = length_q;
                r.checksum_good = (sum_q == rx);
                awaited_results.push_back(r);
                index_q = '0;
                sum_q   = '0;
                phase   = HUNT_FIRST;
            end
        endcase
    endtask

    task automatic check_field(input string field, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            phase     = HUNT_FIRST;
            command_q = '0;
            length_q  = '0;
            index_q   = '0;
            sum_q     = '0;
            awaited_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[RES_DATA_W-1:0]};
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got tuser %0b tdata 0x%0h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("is_frame_end", 16'(want.is_frame_end),
                                16'(got.is_frame_end));
                    check_field("payload_byte", 16'(want.payload_byte),
                                16'(got.payload_byte));
                    check_field("payload_index", want.payload_index, got.payload_index);
                    check_field("command_word", want.command_word, got.command_word);
                    check_field("frame_length", want.frame_length, got.frame_length);
                    check_field("checksum_good", 16'(want.checksum_good),
                                16'(got.checksum_good));
                    check_field("tdata padding", '0,
                                16'(m_tdata[M_TDATA_W-1:RES_DATA_W]));
                    if (want.is_frame_end) begin
                        frame_count++;
                        if (!want.checksum_good) begin
                            bad_sum_count++;
                        end
                    end else begin
                        payload_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata);
            end
        end
        results_due = awaited_results.size();
    end

endmodule

[dv/sync_length_checksum_deframer_tb.sv]
module sync_length_checksum_deframer_tb;
    import sldf_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int LONG_HOLD       = 400;
    localparam int BYTES_PER_PHASE = 400;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    idle_mode_t idle_mode = IDLE_NONE;
    int         holds_asked = 0;
    int         holds_served = 0;
    int         hold_left = 0;
    int         stuck_cycles = 0;
    int         bytes_sent = 0;

    int mismatches;
    int results_due;
    int payload_count;
    int frame_count;
    int bad_sum_count;

    always #1 aclk = ~aclk;

    sync_length_checksum_deframer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sldf_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .mismatches    (mismatches),
        .results_due   (results_due),
        .payload_count (payload_count),
        .frame_count   (frame_count),
        .bad_sum_count (bad_sum_count)
    );

    function automatic int sender_idle_pct(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER: return 58;
            IDLE_BOTH:   return 32;
            default:     return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct(input idle_mode_t mode);
        case (mode)
            IDLE_RECEIVER: return 58;
            IDLE_BOTH:     return 32;
            default:       return 0;
        endcase
    endfunction

    // hold off for a long stretch on request, else stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_asked != holds_served) begin
            m_tready     <= 1'b0;
            hold_left    <= LONG_HOLD;
            holds_served <= holds_asked;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct(idle_mode));
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STALL_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] rx);
        while ($urandom_range(99) < sender_idle_pct(idle_mode)) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        bytes_sent++;
    endtask

    // fill < 0 gives random payload bytes
    task automatic send_frame(input logic [WORD_W-1:0] cmd, input logic [WORD_W-1:0] len,
                              input bit bad_sum, input int fill);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        sum = '0;
        send_byte(SYNC_BYTE);
        send_byte(SYNC_BYTE);
        send_byte(cmd[7:0]);
        send_byte(cmd[15:8]);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        for (int i = 0; i < int'(len); i++) begin
            b   = (fill < 0) ? 8'($urandom) : 8'(fill);
            sum = sum + b;
            send_byte(b);
        end
        send_byte(bad_sum ? sum + 8'($urandom_range(255, 1)) : sum);
    endtask

    task automatic send_random_traffic(input int count);
        int start;
        int pick;
        int len;
        start = bytes_sent;
        while (bytes_sent - start < count) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(254)));
            end else if (pick < 14) begin
                send_byte(SYNC_BYTE);
                send_byte(8'($urandom_range(254)));
            end else begin
                pick = $urandom_range(99);
                if (pick < 10) begin
                    len = 0;
                end else if (pick < 85) begin
                    len = $urandom_range(12, 1);
                end else if (pick < 98) begin
                    len = $urandom_range(48, 13);
                end else begin
                    len = $urandom_range(300, 256);
                end
                send_frame(16'($urandom), 16'(len), $urandom_range(99) < 30, -1);
            end
        end
    endtask

    // stop offering and wait until every expected result has come
    task automatic drain_results;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (results_due == 0);
        @(posedge aclk);
    endtask

    initial begin
        idle_mode_t modes[4];
        modes = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // noise, broken sync, empty frame, all-ones frame, bad checksum
        send_byte(8'h00);
        send_byte(SYNC_BYTE);
        send_byte(8'h7E);
        send_frame(16'h0000, 16'h0000, 1'b0, 0);
        send_frame(16'hFFFF, 16'h0001, 1'b0, 8'hFF);
        send_frame(16'h1234, 16'h0002, 1'b1, -1);
        drain_results();

        // hold the receiver while the sender keeps offering bytes
        holds_asked <= holds_asked + 1;
        send_frame(16'hA55A, 16'd60, 1'b0, -1);
        drain_results();

        foreach (modes[k]) begin
            idle_mode <= modes[k];
            @(posedge aclk);
            send_random_traffic(BYTES_PER_PHASE);
            drain_results();
        end

        idle_mode <= IDLE_NONE;
        @(posedge aclk);
        send_frame(16'($urandom), 16'h0123, 1'b0, -1);
        drain_results();
        repeat (10) @(posedge aclk);

        $display("Sent %0d bytes under four idling patterns and one long receiver hold-off",
                 bytes_sent);
        $display("Checked %0d payload results and %0d frame ends (%0d with checksum error)",
                 payload_count, frame_count, bad_sum_count);
        if (results_due != 0) begin
            $display("%0t: missing results, expected %0d more, got none", $time, results_due);
        end
        if (mismatches == 0 && results_due == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
